/* rtl/btp_pkg.sv */
// Shared types and constants for the bounce trajectory predictor.
// No dependencies; the controller, datapath, top level and bench import this package.
package btp_pkg;

  localparam int MaxPoints  = 64;
  localparam int ResultCap  = 64;
  // points per run: never more than the result limit nor fewer than two
  localparam int PointLimit = (MaxPoints > ResultCap) ? ResultCap :
                              ((MaxPoints < 2) ? 2 : MaxPoints);
  localparam int PointW     = (PointLimit > 2) ? $clog2(PointLimit) : 1;
  localparam int ProdW      = 11 + PointW;
  // internal x: wide enough for any run of reflections within the limit
  localparam int XW         = 20;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t RegLeftBorder  = 1'b0;
  localparam cfg_index_t RegRightBorder = 1'b1;

  localparam logic signed [10:0] LeftBorderReset  = -11'sd120;
  localparam logic        [9:0]  RightBorderReset = 10'd120;

  typedef enum logic [1:0] {
    StComplete  = 2'd0,
    StNoDescent = 2'd1,
    StTruncated = 2'd2
  } run_status_t;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlPrep,
    CtlClassify,
    CtlEmit
  } ctl_state_t;

  typedef struct packed {
    logic capture;   // latch the input item
    logic prep;      // step sizes, direction, start point
    logic classify;  // run status
    logic load;      // load the next point into the output register
  } btp_cmd_t;

  typedef struct packed {
    logic point_last;  // the point being loaded ends the run
  } btp_sts_t;

endpackage

/* rtl/btp_in_if.sv */
// Input channel: one pair of observed puck positions.
// Depends on nothing.
interface btp_in_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] first_x;
  logic signed [10:0] first_y;
  logic signed [10:0] second_x;
  logic signed [10:0] second_y;

  modport source (output valid, first_x, first_y, second_x, second_y, input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

/* rtl/btp_out_if.sv */
// Output channel: one path point per transfer.
// Depends on nothing.
interface btp_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] point_x;
  logic signed [10:0] point_y;
  logic        [5:0]  point_number;
  logic               last_point;
  logic        [1:0]  run_status;

  modport source (output valid, point_x, point_y, point_number, last_point, run_status,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_number, last_point, run_status,
                  output ready);
endinterface

/* rtl/btp_ctrl.sv */
// Controller: sequences capture, set-up, classification and point emission.
// Depends on btp_pkg.
module btp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output btp_pkg::btp_cmd_t cmd,
  input  btp_pkg::btp_sts_t sts
);
  import btp_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;
  logic       can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CtlIdle;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // output register is free when empty or being transferred this cycle
  assign can_load = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      CtlIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = CtlPrep;
        end
      end
      CtlPrep: begin
        cmd.prep   = 1'b1;
        state_next = CtlClassify;
      end
      CtlClassify: begin
        cmd.classify = 1'b1;
        state_next   = CtlEmit;
      end
      CtlEmit: begin
        if (can_load) begin
          cmd.load = 1'b1;
          if (sts.point_last) state_next = CtlIdle;
        end
      end
      default: state_next = CtlIdle;
    endcase
    out_valid_next = cmd.load ? 1'b1 : (out_valid && !out_ready);
  end

endmodule

/* rtl/btp_datapath.sv */
// Datapath: wall registers, step sizes, run status, x/y stepping with
// reflection, and the output point register. Depends on btp_pkg.
module btp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  btp_pkg::btp_cmd_t   cmd,
  output btp_pkg::btp_sts_t   sts,
  input  logic                cfg_write,
  input  btp_pkg::cfg_index_t cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic signed [10:0]  first_x,
  input  logic signed [10:0]  first_y,
  input  logic signed [10:0]  second_x,
  input  logic signed [10:0]  second_y,
  output logic signed [12:0]  point_x,
  output logic signed [10:0]  point_y,
  output logic [5:0]          point_number,
  output logic                last_point,
  output logic [1:0]          run_status
);
  import btp_pkg::*;

  logic signed [10:0]    left_border;
  logic        [9:0]     right_border;
  logic signed [10:0]    x1, y1, x2, y2;
  logic        [10:0]    dx, dy;
  logic                  dir_right;
  logic signed [XW-1:0]  x_pos;
  logic signed [11:0]    y_pos;
  run_status_t           status;
  logic [PointW-1:0]     k;

  logic signed [11:0]    diff_x, diff_y;
  logic        [ProdW-1:0] prod;
  logic                  y2_pos;
  run_status_t           status_next;
  logic signed [XW-1:0]  dx_ext, rb_ext, lb_ext, x_try, x_new;
  logic                  dir_next;
  logic signed [11:0]    y_new;
  logic                  last_lim, seed_last, step_last;
  logic signed [12:0]    x_sat;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      left_border  <= LeftBorderReset;
      right_border <= RightBorderReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegLeftBorder:  left_border  <= $signed(cfg_data);
        RegRightBorder: right_border <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // ---- set-up ----
  // taken from the captured item; the input ports are free once it is latched
  assign diff_x = {x2[10], x2} - {x1[10], x1};
  assign diff_y = {y2[10], y2} - {y1[10], y1};

  assign y2_pos = !y2[10] && (|y2[9:0]);
  assign prod   = ProdW'(dy) * ProdW'(PointLimit - 1);

  always_comb begin
    if (y2_pos && dy == '0)                      status_next = StNoDescent;
    else if (y2_pos && ProdW'(y2[9:0]) >= prod)  status_next = StTruncated;
    else                                         status_next = StComplete;
  end

  // ---- one prediction step ----
  assign dx_ext = $signed({{(XW-11){1'b0}}, dx});
  assign rb_ext = $signed({{(XW-10){1'b0}}, right_border});
  assign lb_ext = {{(XW-11){left_border[10]}}, left_border};

  always_comb begin
    dir_next = dir_right;
    if (dir_right) begin
      x_try = x_pos + dx_ext;
      x_new = x_try;
      if (x_try >= rb_ext) begin
        x_new    = (rb_ext <<< 1) - x_try;
        dir_next = 1'b0;
      end
    end else begin
      x_try = x_pos - dx_ext;
      x_new = x_try;
      if (x_try <= lb_ext) begin
        x_new    = (lb_ext <<< 1) - x_try;
        dir_next = 1'b1;
      end
    end
  end

  assign y_new = y_pos - $signed({1'b0, dy});

  always_comb begin
    if (x_new > XW'(4095))       x_sat = 13'sd4095;
    else if (x_new < -XW'(4096)) x_sat = -13'sd4096;
    else                         x_sat = x_new[12:0];
  end

  // ---- end-of-run detection ----
  assign last_lim  = (k == PointW'(PointLimit - 1));
  assign seed_last = last_lim || (status == StNoDescent) || !y2_pos ||
                     ($signed({1'b0, y2}) < $signed({1'b0, dy}));
  assign step_last = last_lim || ($signed({y_new[11], y_new}) < $signed({2'b00, dy}));

  always_comb begin
    if (k == PointW'(0))      sts.point_last = last_lim;
    else if (k == PointW'(1)) sts.point_last = seed_last;
    else                      sts.point_last = step_last;
  end

  // ---- working registers ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x1 <= first_x;
      y1 <= first_y;
      x2 <= second_x;
      y2 <= second_y;
    end
    if (cmd.prep) begin
      dir_right <= !diff_x[11];
      dx        <= diff_x[11] ? 11'(-diff_x) : diff_x[10:0];
      dy        <= diff_y[11] ? 11'(-diff_y) : diff_y[10:0];
      x_pos     <= {{(XW-11){x2[10]}}, x2};
      y_pos     <= {y2[10], y2};
      k         <= '0;
    end
    if (cmd.classify) status <= status_next;
    if (cmd.load) begin
      k            <= k + PointW'(1);
      point_number <= 6'(k);
      last_point   <= sts.point_last;
      run_status   <= status;
      if (k == PointW'(0)) begin
        point_x <= {{2{x1[10]}}, x1};
        point_y <= y1;
      end else if (k == PointW'(1)) begin
        point_x <= {{2{x2[10]}}, x2};
        point_y <= y2;
      end else begin
        point_x   <= x_sat;
        point_y   <= y_new[10:0];
        x_pos     <= x_new;
        y_pos     <= y_new;
        dir_right <= dir_next;
      end
    end
  end

endmodule

/* rtl/bounce_trajectory_predictor.sv */
// Bounce trajectory predictor, top level: controller plus datapath.
// Depends on btp_pkg, btp_in_if, btp_out_if, btp_ctrl, btp_datapath.
//
//  port       kind          transfer carries
//  observe    valid/ready   first_x, first_y, second_x, second_y
//  path       valid/ready   point_x, point_y, point_number, last_point, run_status
//  cfg_*      write only    left_border (index 0), right_border (index 1)
//
// Each item goes through set-up (capture, step sizes, status), then one point per
// cycle from the output register while path is not stalled, 2 to 64 points a run.
// A new item is taken in the cycle after the last point of the run is loaded,
// while that point still waits. A stall on path holds the run point by point.
// Synchronous active-high reset clears the controller and restores the walls.
module bounce_trajectory_predictor (
  input  logic                clk,
  input  logic                rst,
  btp_in_if.sink              observe,
  btp_out_if.source           path,
  input  logic                cfg_write,
  input  btp_pkg::cfg_index_t cfg_index,
  input  logic [10:0]         cfg_data
);
  import btp_pkg::*;

  btp_cmd_t cmd;
  btp_sts_t sts;

  btp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (observe.valid),
    .in_ready  (observe.ready),
    .out_valid (path.valid),
    .out_ready (path.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  btp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .first_x      (observe.first_x),
    .first_y      (observe.first_y),
    .second_x     (observe.second_x),
    .second_y     (observe.second_y),
    .point_x      (path.point_x),
    .point_y      (path.point_y),
    .point_number (path.point_number),
    .last_point   (path.last_point),
    .run_status   (path.run_status)
  );

endmodule

/* verif/testbench.sv */
// Self-checking bench for bounce_trajectory_predictor: directed table then random runs,
// every path point checked against the table or an in-bench trajectory predictor.
// Depends on btp_pkg, btp_in_if, btp_out_if and the RTL top level.
module testbench;
  import btp_pkg::*;

  localparam int StallLimit = 2000;
  localparam int IdlePct    = 19;

  typedef struct {
    logic signed [12:0] x;
    logic signed [10:0] y;
    logic        [5:0]  num;
    logic               last;
    run_status_t        status;
  } path_point_t;

  typedef struct packed {
    logic signed [10:0] lb;
    logic        [10:0] rb;
    logic signed [10:0] fx;
    logic signed [10:0] fy;
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    logic               seeds_only;
    run_status_t        status;
  } stim_row_t;

  // seeds_only rows carry their expected status; the rest go through the predictor
  stim_row_t directed_rows [22] = '{
    '{-120, 120, 0, 100, 0, 0, 1'b1, StComplete},
    '{-120, 120, -1024, -1024, 1023, -1024, 1'b1, StComplete},
    '{-120, 120, 10, 60, 20, 50, 1'b0, StComplete},
    '{-120, 120, 100, 300, 110, 200, 1'b0, StComplete},
    '{-120, 120, -100, 300, -110, 200, 1'b0, StComplete},
    '{-120, 120, 5, 500, 5, 500, 1'b1, StNoDescent},
    '{-120, 120, 0, 1023, 0, 1022, 1'b0, StComplete},
    '{-120, 120, -1024, 1023, 1023, -1024, 1'b1, StComplete},
    '{-120, 120, 1023, -1024, -1024, 1023, 1'b0, StComplete},
    '{-120, 120, 0, 0, 0, 0, 1'b1, StComplete},
    '{-120, 120, -1024, 1, 1023, 1, 1'b1, StNoDescent},
    '{-1024, 1023, 0, 1000, 1000, 900, 1'b0, StComplete},
    '{-1024, 1023, 0, 1000, -1000, 990, 1'b0, StComplete},
    '{-1024, 1023, 1023, 20, -1024, 10, 1'b0, StComplete},
    '{0, 0, 0, 10, 1, 5, 1'b0, StComplete},
    '{0, 0, 0, 100, -1, 50, 1'b0, StComplete},
    '{1023, 2047, 0, 200, -5, 100, 1'b0, StComplete},
    '{1023, 0, 1023, 100, -1024, 50, 1'b0, StComplete},
    '{1023, 0, 1023, 99, -1024, 66, 1'b0, StComplete},
    '{-1024, 1024, 1023, 30, 1023, 15, 1'b0, StComplete},
    '{-1024, 1024, -1024, 30, -1024, 29, 1'b0, StComplete},
    '{-1024, 1024, 1000, 1023, -1000, 1, 1'b0, StComplete}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  cfg_index_t  cfg_index;
  logic [10:0] cfg_data;

  btp_in_if  observe_ch ();
  btp_out_if path_ch ();

  bounce_trajectory_predictor dut (
    .clk       (clk),
    .rst       (rst),
    .observe   (observe_ch),
    .path      (path_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  path_point_t        expected_points [$];
  path_point_t        want;
  int                 errors = 0;
  int                 stall_count = 0;
  bit                 quiet = 1'b0;
  int                 left_wall = -120;
  int                 right_wall = 120;
  logic signed [10:0] wall_l_data = LeftBorderReset;
  logic        [10:0] wall_r_data = {1'b0, RightBorderReset};

  always #5 clk = ~clk;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic void add_point(int k, int x, int y, bit last, run_status_t status);
    path_point_t p;
    int xs;
    xs = (x > 4095) ? 4095 : ((x < -4096) ? -4096 : x);
    p.x = 13'(xs);
    p.y = 11'(y);
    p.num = 6'(k);
    p.last = last;
    p.status = status;
    expected_points.insert(expected_points.size(), p);
  endfunction

  // path of one run: step, reflect at most once off the wall ahead, descend
  function automatic void predict_path(logic signed [10:0] fx, fy, sx, sy);
    int dx, dy, x, y, n, total;
    bit right;
    run_status_t status;
    dx = (sx >= fx) ? sx - fx : fx - sx;
    dy = (sy >= fy) ? sy - fy : fy - sy;
    right = (sx >= fx);
    status = StComplete;
    if (sy > 0 && dy == 0) begin
      status = StNoDescent;
      total = 2;
    end else begin
      n = 0;
      if (sy > 0) n = sy / dy;
      total = 2 + n;
      if (total > PointLimit) begin
        status = StTruncated;
        total = PointLimit;
      end
    end
    add_point(0, fx, fy, total == 1, status);
    add_point(1, sx, sy, total == 2, status);
    x = sx;
    y = sy;
    for (int k = 2; k < total; k++) begin
      if (right) begin
        x += dx;
        if (x >= right_wall) begin
          x = 2 * right_wall - x;
          right = 1'b0;
        end
      end else begin
        x -= dx;
        if (x <= left_wall) begin
          x = 2 * left_wall - x;
          right = 1'b1;
        end
      end
      y -= dy;
      add_point(k, x, y, k == total - 1, status);
    end
  endfunction

  // called in the step of the last transfer, so lowering valid here is its only update
  task automatic set_walls(logic signed [10:0] l, logic [10:0] r);
    observe_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= RegLeftBorder;
    cfg_data  <= l;
    @(posedge clk);
    cfg_index <= RegRightBorder;
    cfg_data  <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
    wall_l_data = l;
    wall_r_data = r;
    left_wall = l;
    right_wall = r[9:0];
  endtask

  task automatic send_item(logic signed [10:0] fx, fy, sx, sy);
    if (!quiet) begin
      while ($urandom_range(99) < IdlePct) begin
        observe_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    observe_ch.valid    <= 1'b1;
    observe_ch.first_x  <= fx;
    observe_ch.first_y  <= fy;
    observe_ch.second_x <= sx;
    observe_ch.second_y <= sy;
    @(posedge clk);
    while (!observe_ch.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    path_ch.ready <= quiet || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    if (!rst && path_ch.valid && path_ch.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected point number %0d", path_ch.point_number));
      end else begin
        want = expected_points.pop_front();
        if (path_ch.point_x !== want.x)
          report_mismatch($sformatf("point %0d x %0d, want %0d", want.num,
                                    path_ch.point_x, want.x));
        if (path_ch.point_y !== want.y)
          report_mismatch($sformatf("point %0d y %0d, want %0d", want.num,
                                    path_ch.point_y, want.y));
        if (path_ch.point_number !== want.num)
          report_mismatch($sformatf("point number %0d, want %0d", path_ch.point_number,
                                    want.num));
        if (path_ch.last_point !== want.last)
          report_mismatch($sformatf("point %0d last %b, want %b", want.num,
                                    path_ch.last_point, want.last));
        if (path_ch.run_status !== want.status)
          report_mismatch($sformatf("point %0d status %0d, want %0d", want.num,
                                    path_ch.run_status, want.status));
      end
    end
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (observe_ch.valid && observe_ch.ready) || (path_ch.valid && path_ch.ready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    logic signed [10:0] fx, fy, sx, sy;
    logic signed [10:0] l;
    logic        [10:0] r;
    int                 kind;

    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = RegLeftBorder;
    cfg_data            = '0;
    observe_ch.valid    = 1'b0;
    observe_ch.first_x  = '0;
    observe_ch.first_y  = '0;
    observe_ch.second_x = '0;
    observe_ch.second_y = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.lb != wall_l_data || row.rb != wall_r_data) set_walls(row.lb, row.rb);
      send_item(row.fx, row.fy, row.sx, row.sy);
      if (row.seeds_only) begin
        add_point(0, row.fx, row.fy, 1'b0, row.status);
        add_point(1, row.sx, row.sy, 1'b1, row.status);
      end else begin
        predict_path(row.fx, row.fy, row.sx, row.sy);
      end
    end

    // four wall settings; the third runs with no idling on either side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          l = -11'sd1024;
          r = 11'd1023;
        end
        1: begin
          l = 11'sd0;
          r = 11'd0;
        end
        default: begin
          l = 11'($urandom);
          r = 11'($urandom);
        end
      endcase
      set_walls(l, r);
      quiet = (ph == 2);
      for (int j = 0; j < 35; j++) begin
        kind = $urandom_range(99);
        fx = 11'($urandom);
        sx = 11'($urandom);
        fy = 11'($urandom);
        if (kind < 60) begin
          sy = 11'($urandom_range(1, 1023));
        end else if (kind < 75) begin
          sy = 11'($urandom);
        end else if (kind < 85) begin
          sy = 11'($urandom_range(1, 1023));
          fy = sy;
        end else begin
          // shallow descent: long runs, often truncated
          sy = 11'($urandom_range(1, 1023));
          fy = sy - 11'($urandom_range(1, 40));
        end
        send_item(fx, fy, sx, sy);
        predict_path(fx, fy, sx, sy);
      end
    end
    quiet = 1'b0;
    observe_ch.valid <= 1'b0;

    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

/* bounce_trajectory_predictor.f */
rtl/btp_pkg.sv
rtl/btp_in_if.sv
rtl/btp_out_if.sv
rtl/btp_ctrl.sv
rtl/btp_datapath.sv
rtl/bounce_trajectory_predictor.sv
verif/testbench.sv
